// ===== src/slum_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the sorted list union merge block:
// mode and status codes, default sizes, controller/datapath handshake structs.
package slum_pkg;

	// Default sizes
	localparam int DEF_LIST_DEPTH = 32;
	localparam int DEF_VALUE_BITS = 20;

	// Request modes
	localparam logic [1:0] MODE_LOAD_A = 2'd0;
	localparam logic [1:0] MODE_LOAD_B = 2'd1;
	localparam logic [1:0] MODE_MERGE  = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_LOADED    = 3'd0;
	localparam logic [2:0] ST_ORDER_ERR = 3'd1;
	localparam logic [2:0] ST_FULL_ERR  = 3'd2;
	localparam logic [2:0] ST_ELEM      = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;     // append the request value to a list
		logic sel_b;    // list B when set, list A otherwise
		logic advance;  // consume the smaller list head
		logic finish;   // emit the final result and clear both lists
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic can_push;  // output register is free or being drained
		logic done;      // both list heads exhausted
		logic distinct;  // current head differs from the pending value
		logic have;      // a pending value is held
	} sts_t;

endpackage

// ===== src/sorted_list_union_merge_top.sv =====
`timescale 1ns / 1ps
// Top level of the sorted list union merge block.
// Depends on slum_pkg, slum_ctrl, slum_dp (and slum_ram through slum_dp).
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------
// in       | input     | in_valid/in_stall  | mode, value
// out      | output    | out_valid/out_stall| value_res, status, last
//
// A load request gives one acknowledge; loads can be taken every cycle while the output
// register can take it. A merge run reads each list element from the list RAMs in turn,
// then emits the final result; out_stall on the output register makes it run longer.
// Each list RAM has one read port, so the merge consumes one list element per cycle
// unless stalled. No request is taken during a merge run. Reset empties both lists at once.
module sorted_list_union_merge_top #(
	parameter int LIST_DEPTH = slum_pkg::DEF_LIST_DEPTH,
	parameter int VALUE_BITS = slum_pkg::DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VALUE_BITS-1:0] value_res,
	output logic [2:0]            status,
	output logic                  last
);
	import slum_pkg::*;

	cmd_t cmd;
	sts_t sts;

	slum_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	slum_dp #(.LIST_DEPTH(LIST_DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_res (value_res),
		.status    (status),
		.last      (last)
	);

endmodule

// ===== src/slum_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slum_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/slum_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the sorted list union merge: request intake and merge run sequencing.
// Depends on slum_pkg.
module slum_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  slum_pkg::sts_t    sts,
	output slum_pkg::cmd_t    cmd
);
	import slum_pkg::*;

	typedef enum logic {S_IDLE, S_MERGE} state_t;

	state_t state_q;
	logic   accept;
	logic   start;

	// Take requests only while idle and the output register can take the acknowledge
	assign in_stall = (state_q != S_IDLE) || !sts.can_push;
	assign accept   = in_valid && !in_stall;
	assign start    = accept && (mode == MODE_MERGE);

	// Decode commands
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load  = accept && (mode == MODE_LOAD_A || mode == MODE_LOAD_B);
				cmd.sel_b = (mode == MODE_LOAD_B);
			end
			S_MERGE: begin
				cmd.advance = !sts.done && (!(sts.distinct && sts.have) || sts.can_push);
				cmd.finish  = sts.done && sts.can_push;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_MERGE;
				end
				S_MERGE: begin
					if (cmd.finish) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// No request is taken during a merge run
	a_no_accept_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE) |-> in_stall)
		else $error("request accepted during merge run");

	// A merge run never issues load commands
	a_no_load_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE) |-> !cmd.load)
		else $error("load command during merge run");

endmodule

// ===== src/slum_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the sorted list union merge: list RAMs, counts, merge pointers,
// pending value and output register. Depends on slum_pkg and slum_ram.
module slum_dp #(
	parameter int LIST_DEPTH = slum_pkg::DEF_LIST_DEPTH,
	parameter int VALUE_BITS = slum_pkg::DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [VALUE_BITS-1:0] value,
	input  slum_pkg::cmd_t        cmd,
	output slum_pkg::sts_t        sts,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VALUE_BITS-1:0] value_res,
	output logic [2:0]            status,
	output logic                  last
);
	import slum_pkg::*;

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

	logic [CW-1:0]         cnt_a_q, cnt_b_q, ptr_a_q, ptr_b_q;
	logic [CW-1:0]         ptr_a_d, ptr_b_d, cnt_sel;
	logic [VALUE_BITS-1:0] last_a_q, last_b_q, last_sel;
	logic [VALUE_BITS-1:0] prev_q, rd_a, rd_b, head;
	logic                  have_q;
	logic                  out_valid_q, last_q;
	logic [VALUE_BITS-1:0] value_res_q;
	logic [2:0]            status_q;
	logic                  a_done, b_done, take_a, distinct;
	logic                  is_full, is_order, load_ok, we_a, we_b;
	logic                  push, can_push;
	logic [2:0]            load_st;

	// Check an append against the selected list
	assign cnt_sel  = cmd.sel_b ? cnt_b_q : cnt_a_q;
	assign last_sel = cmd.sel_b ? last_b_q : last_a_q;
	assign is_full  = (cnt_sel >= FULL_CNT);
	assign is_order = (cnt_sel != '0) && (value < last_sel);
	assign load_ok  = !is_full && !is_order;
	assign load_st  = is_full ? ST_FULL_ERR : (is_order ? ST_ORDER_ERR : ST_LOADED);
	assign we_a     = cmd.load && load_ok && !cmd.sel_b;
	assign we_b     = cmd.load && load_ok && cmd.sel_b;

	// Pick the smaller head; A wins ties
	assign a_done   = (ptr_a_q >= cnt_a_q);
	assign b_done   = (ptr_b_q >= cnt_b_q);
	assign take_a   = b_done || (!a_done && (rd_a <= rd_b));
	assign head     = take_a ? rd_a : rd_b;
	assign distinct = !have_q || (head != prev_q);

	// Advance pointers; read address follows the next pointer so data lines up
	always_comb begin
		ptr_a_d = ptr_a_q;
		ptr_b_d = ptr_b_q;
		if (cmd.finish) begin
			ptr_a_d = '0;
			ptr_b_d = '0;
		end else if (cmd.advance) begin
			if (take_a) ptr_a_d = ptr_a_q + 1'b1;
			else        ptr_b_d = ptr_b_q + 1'b1;
		end
	end

	slum_ram #(.WIDTH(VALUE_BITS), .DEPTH(LIST_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[AW-1:0]),
		.wdata (value),
		.raddr (ptr_a_d[AW-1:0]),
		.rdata (rd_a)
	);

	slum_ram #(.WIDTH(VALUE_BITS), .DEPTH(LIST_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[AW-1:0]),
		.wdata (value),
		.raddr (ptr_b_d[AW-1:0]),
		.rdata (rd_b)
	);

	// Status to the controller
	assign can_push     = !out_valid_q || !out_stall;
	assign sts.can_push = can_push;
	assign sts.done     = a_done && b_done;
	assign sts.distinct = distinct;
	assign sts.have     = have_q;

	assign push = cmd.load || cmd.finish || (cmd.advance && distinct && have_q);

	// Hold counts, pointers and the pending value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ptr_a_q <= '0;
			ptr_b_q <= '0;
			have_q  <= 1'b0;
		end else begin
			ptr_a_q <= ptr_a_d;
			ptr_b_q <= ptr_b_d;
			if (cmd.finish) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				have_q  <= 1'b0;
			end else begin
				if (we_a) cnt_a_q <= cnt_a_q + 1'b1;
				if (we_b) cnt_b_q <= cnt_b_q + 1'b1;
				if (cmd.advance && distinct) have_q <= 1'b1;
			end
		end
	end

	// Track last element of each list and the pending union value
	always_ff @(posedge clk) begin
		if (we_a) last_a_q <= value;
		if (we_b) last_b_q <= value;
		if (cmd.advance && distinct) prev_q <= head;
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (push) begin
			if (cmd.load) begin
				value_res_q <= '0;
				status_q    <= load_st;
				last_q      <= 1'b1;
			end else if (cmd.finish) begin
				value_res_q <= have_q ? prev_q : '0;
				status_q    <= have_q ? ST_ELEM : ST_EMPTY;
				last_q      <= 1'b1;
			end else begin
				value_res_q <= prev_q;
				status_q    <= ST_ELEM;
				last_q      <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = value_res_q;
	assign status    = status_q;
	assign last      = last_q;

	// Counts never pass the list depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= FULL_CNT) && (cnt_b_q <= FULL_CNT))
		else $error("list count beyond depth");

	// Merge pointers never run past the counts
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_a_q <= cnt_a_q) && (ptr_b_q <= cnt_b_q))
		else $error("merge pointer beyond list count");

	// A finished run leaves both lists empty
	a_finish_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (cnt_a_q == '0) && (cnt_b_q == '0) && !have_q)
		else $error("lists not cleared after merge run");

	// Never overwrite a result that is still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> can_push)
		else $error("output register overrun");

endmodule

// ===== bench/union_check_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sorted list union merge testbench: keeps its own copy of
// both lists, predicts the results of each request and checks them in order.
// Depends on slum_pkg for the mode and status codes and the default sizes.
package union_check_pkg;
	import slum_pkg::*;

	localparam int VALUE_W    = DEF_VALUE_BITS;
	localparam int LIST_D     = DEF_LIST_DEPTH;
	localparam int REPORT_MAX = 40;

	class union_scoreboard;
		typedef struct packed {
			logic [VALUE_W-1:0] value_res;
			logic [2:0]         status;
			logic               last;
		} result_t;

		logic [VALUE_W-1:0] lists[2][LIST_D];
		int unsigned        fill[2];
		result_t            expected_q[$];
		int                 errors;

		function new();
			fill[0] = 0;
			fill[1] = 0;
			errors  = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void add_expected(logic [VALUE_W-1:0] v, logic [2:0] st, logic l);
			result_t r;
			r.value_res = v;
			r.status    = st;
			r.last      = l;
			expected_q.insert(expected_q.size(), r);
		endfunction

		// Predict the results of one accepted request
		function void note_request(logic [1:0] m, logic [VALUE_W-1:0] v);
			int unsigned        sel;
			int unsigned        ia;
			int unsigned        ib;
			logic [VALUE_W-1:0] cur;
			logic [VALUE_W-1:0] prev;
			bit                 have;
			case (m)
				MODE_LOAD_A, MODE_LOAD_B: begin
					sel = (m == MODE_LOAD_B) ? 1 : 0;
					if (fill[sel] >= LIST_D) begin
						add_expected('0, ST_FULL_ERR, 1'b1);
					end else if (fill[sel] > 0 && v < lists[sel][fill[sel]-1]) begin
						add_expected('0, ST_ORDER_ERR, 1'b1);
					end else begin
						lists[sel][fill[sel]] = v;
						fill[sel]++;
						add_expected('0, ST_LOADED, 1'b1);
					end
				end
				MODE_MERGE: begin
					ia   = 0;
					ib   = 0;
					prev = '0;
					have = 1'b0;
					// take the smaller head each step, drop repeats of the previous value
					while (ia < fill[0] || ib < fill[1]) begin
						if (ib >= fill[1] || (ia < fill[0] && lists[0][ia] <= lists[1][ib])) begin
							cur = lists[0][ia];
							ia++;
						end else begin
							cur = lists[1][ib];
							ib++;
						end
						if (!have || cur != prev) begin
							add_expected(cur, ST_ELEM, 1'b0);
							prev = cur;
							have = 1'b1;
						end
					end
					if (!have)
						add_expected('0, ST_EMPTY, 1'b1);
					else
						expected_q[expected_q.size()-1].last = 1'b1;
					fill[0] = 0;
					fill[1] = 0;
				end
				default: begin
					// unused mode: no result, lists untouched
				end
			endcase
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(logic [VALUE_W-1:0] v, logic [2:0] st, logic l);
			result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: unexpected result value_res=%0d status=%0d last=%0d",
						$time, v, st, l);
				return;
			end
			want = expected_q.pop_front();
			if (v !== want.value_res || st !== want.status || l !== want.last) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: expected value_res=%0d status=%0d last=%0d, got %0d %0d %0d",
						$time, want.value_res, want.status, want.last, v, st, l);
			end
		endfunction
	endclass

endpackage

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for sorted_list_union_merge_top: directed and random list loads and
// merges, bursty requests and a patterned output stall, checked by a scoreboard.
// Depends on slum_pkg and union_check_pkg.
module testbench;
	import slum_pkg::*;
	import union_check_pkg::*;

	localparam logic [1:0]  MODE_UNUSED  = 2'd3;
	localparam int unsigned VALUE_MAX    = (1 << VALUE_W) - 1;
	localparam int          ITEM_TARGET  = 120;
	localparam int          IDLE_LIMIT   = 2000;
	localparam int          DRAIN_CYCLES = 80;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PULSE} stall_style_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         mode;
	logic [VALUE_W-1:0] value;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [VALUE_W-1:0] value_res;
	logic [2:0]         status;
	logic               last;

	union_scoreboard sb;
	int              burst_left    = 0;
	int              requests_sent = 0;
	int              idle_cycles   = 0;
	stall_style_t    stall_style   = STALL_NONE;
	int              style_left    = 0;

	wire req_taken = (in_valid === 1'b1) && (in_stall === 1'b0);
	wire res_taken = (out_valid === 1'b1) && (out_stall === 1'b0);

	sorted_list_union_merge_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_res (value_res),
		.status    (status),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Send one request, opening a new burst after a random gap when the last one ran out
	task automatic send_request(input logic [1:0] m, input logic [VALUE_W-1:0] v);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		mode     <= m;
		value    <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		burst_left--;
		if (m != MODE_UNUSED)
			requests_sent++;
	endtask

	// Load two ascending lists in random interleaving, with some noise mixed in
	task automatic load_lists(input int len_a, input int len_b, input int unsigned base,
			input int unsigned max_step);
		int          len[2];
		int          sent[2];
		int unsigned next_val[2];
		int unsigned last_val[2];
		int unsigned sel;
		len[0] = len_a;
		len[1] = len_b;
		for (int k = 0; k < 2; k++) begin
			sent[k]     = 0;
			last_val[k] = 0;
			next_val[k] = base + $urandom_range(0, max_step);
			if (next_val[k] > VALUE_MAX)
				next_val[k] = VALUE_MAX;
		end
		while (sent[0] < len[0] || sent[1] < len[1]) begin
			if (sent[0] >= len[0])
				sel = 1;
			else if (sent[1] >= len[1])
				sel = 0;
			else
				sel = $urandom_range(0, 1);
			// drop in an unused mode or an out-of-order value now and then
			if ($urandom_range(0, 24) == 0)
				send_request(MODE_UNUSED, VALUE_W'($urandom()));
			if (sent[sel] > 0 && last_val[sel] > 0 && $urandom_range(0, 11) == 0)
				send_request(sel ? MODE_LOAD_B : MODE_LOAD_A,
					VALUE_W'($urandom_range(0, last_val[sel] - 1)));
			send_request(sel ? MODE_LOAD_B : MODE_LOAD_A, VALUE_W'(next_val[sel]));
			last_val[sel] = next_val[sel];
			sent[sel]++;
			// advance, leaving a repeat in about a quarter of the steps
			if ($urandom_range(0, 3) != 0)
				next_val[sel] += $urandom_range(1, max_step);
			if (next_val[sel] > VALUE_MAX)
				next_val[sel] = VALUE_MAX;
		end
	endtask

	// Stall the output in changing styles
	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 3));
			style_left  = $urandom_range(4, 60);
		end else begin
			style_left--;
		end
		case (stall_style)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= style_left[2];
		endcase
	end

	// Note accepted requests, check accepted results, count idle cycles
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (req_taken)
				sb.note_request(mode, value);
			if (res_taken)
				sb.check_result(value_res, status, last);
		end
		if (req_taken || res_taken)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// End the run when nothing moves for too long
	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
		$display("[sorted_list_union_merge_top] ERROR");
		$finish;
	end

	initial begin
		int          len_a;
		int          len_b;
		int unsigned base;
		int unsigned step;
		sb = new();
		in_valid <= 1'b0;
		mode     <= MODE_LOAD_A;
		value    <= '0;
		arst_n   <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// merge with both lists empty, then an unused mode
		send_request(MODE_MERGE, '0);
		send_request(MODE_UNUSED, VALUE_W'(VALUE_MAX));
		// extremes, an out-of-order value and repeats within and across lists
		send_request(MODE_LOAD_A, '0);
		send_request(MODE_LOAD_A, VALUE_W'(VALUE_MAX));
		send_request(MODE_LOAD_A, VALUE_W'(5));
		send_request(MODE_LOAD_A, VALUE_W'(VALUE_MAX));
		send_request(MODE_LOAD_B, '0);
		send_request(MODE_LOAD_B, '0);
		send_request(MODE_LOAD_B, VALUE_W'(20'h55555));
		send_request(MODE_LOAD_B, VALUE_W'(3));
		send_request(MODE_LOAD_B, VALUE_W'(20'hAAAAA));
		send_request(MODE_MERGE, VALUE_W'(VALUE_MAX));
		// list A empty, then list B empty
		send_request(MODE_LOAD_B, VALUE_W'(7));
		send_request(MODE_LOAD_B, VALUE_W'(9));
		send_request(MODE_MERGE, '0);
		send_request(MODE_LOAD_A, VALUE_W'(42));
		send_request(MODE_MERGE, '0);
		send_request(MODE_UNUSED, '0);

		// overfill list A first, then mostly short lists
		load_lists(LIST_D + 2, 3, 1000, 50);
		send_request(MODE_MERGE, VALUE_W'($urandom()));
		while (requests_sent < ITEM_TARGET) begin
			len_a = ($urandom_range(0, 9) == 0) ? $urandom_range(7, LIST_D + 2)
				: $urandom_range(0, 6);
			len_b = ($urandom_range(0, 9) == 0) ? $urandom_range(7, LIST_D + 2)
				: $urandom_range(0, 6);
			case ($urandom_range(0, 3))
				0:       base = 0;
				1:       base = VALUE_MAX - $urandom_range(0, 64);
				default: base = $urandom_range(0, VALUE_MAX);
			endcase
			case ($urandom_range(0, 3))
				0:       step = 1;
				1:       step = 8;
				2:       step = 4096;
				default: step = 65536;
			endcase
			load_lists(len_a, len_b, base, step);
			send_request(MODE_MERGE, VALUE_W'($urandom()));
		end
		in_valid <= 1'b0;

		// drain, then watch for stray results
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[sorted_list_union_merge_top] OK");
		else
			$display("[sorted_list_union_merge_top] ERROR");
		$finish;
	end

endmodule
